// ===== sv/sobel_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Sobel edge detector.
// Used by sobel_grad and sobel_edge_threshold; depends on nothing else.
package sobel_pkg;

  // Default buffer geometry handed to the top level parameters.
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned OUT_ROW_W  = 10;
  localparam int unsigned OUT_COL_W  = 10;
  localparam int unsigned MAG_W      = 8;
  localparam int unsigned EDGE_W     = 8;
  localparam int unsigned OUT_USED_W = OUT_ROW_W + OUT_COL_W + MAG_W + EDGE_W;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned IN_DATA_W  = ((PIX_W + 7) / 8) * 8;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DIM_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST    = 11'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST   = 11'd480;
  localparam logic [MAG_W-1:0] EDGE_THRESHOLD_RST = 8'd35;

  localparam logic [EDGE_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [EDGE_W-1:0] EDGE_OFF = 8'd0;

  // One column of the 3x3 neighborhood: rows r-2, r-1 and r.
  typedef struct packed {
    logic [PIX_W-1:0] o;
    logic [PIX_W-1:0] n;
    logic [PIX_W-1:0] p;
  } sobel_col_t;

  // One result request: the eight taps the kernels use, plus position.
  typedef struct packed {
    logic [PIX_W-1:0]     tl;
    logic [PIX_W-1:0]     tc;
    logic [PIX_W-1:0]     tr;
    logic [PIX_W-1:0]     ml;
    logic [PIX_W-1:0]     mr;
    logic [PIX_W-1:0]     bl;
    logic [PIX_W-1:0]     bc;
    logic [PIX_W-1:0]     br;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } sobel_req_t;

  // Clamps a dimension to [2, maxv] and returns the index of its last element.
  function automatic logic [12:0] dim_last(input logic [DIM_W-1:0] v,
                                           input logic [12:0] maxv);
    logic [12:0] r;
    if (v < 11'd2) begin
      r = 13'd1;
    end else if ({2'b00, v} > maxv) begin
      r = maxv - 13'd1;
    end else begin
      r = {2'b00, v} - 13'd1;
    end
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] sat_abs(input logic signed [10:0] v);
    logic [10:0] a;
    a = v[10] ? 11'(-v) : 11'(v);
    return (a > 11'd255) ? 8'd255 : a[7:0];
  endfunction

  // Mean of two magnitudes, ties rounded to even.
  function automatic logic [MAG_W-1:0] round_mean(input logic [MAG_W-1:0] a,
                                                  input logic [MAG_W-1:0] b);
    logic [8:0] s;
    logic [8:0] q;
    s = {1'b0, a} + {1'b0, b};
    q = {1'b0, s[8:1]};
    if (s[0] && q[0]) begin
      q = q + 9'd1;
    end
    return q[7:0];
  endfunction

endpackage

// ===== sv/sobel_grad.sv =====
// Gradient and magnitude pipeline: kernel sums, saturation, rounded mean,
// threshold and the output register. Depends on sobel_pkg.
module sobel_grad (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  sobel_pkg::sobel_req_t               req_i,
  input  logic [sobel_pkg::MAG_W-1:0]         thresh_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  // out_data_o: out_row, out_col, gradient_magnitude, edge_pixel, zero pad
  output logic [sobel_pkg::OUT_DATA_W-1:0]    out_data_o,
  output logic                                out_last_o
);
  import sobel_pkg::*;

  logic [9:0]           sum_l, sum_r, sum_t, sum_b;
  logic signed [10:0]   gx, gy;

  logic                 g_v_q;
  logic [MAG_W-1:0]     ax_q, ay_q;
  logic [OUT_ROW_W-1:0] g_row_q;
  logic [OUT_COL_W-1:0] g_col_q;
  logic                 g_last_q;
  logic                 g_ready;

  logic                 o_v_q;
  logic [MAG_W-1:0]     o_mag_q;
  logic [EDGE_W-1:0]    o_edge_q;
  logic [OUT_ROW_W-1:0] o_row_q;
  logic [OUT_COL_W-1:0] o_col_q;
  logic                 o_last_q;
  logic                 o_ready;
  logic [MAG_W-1:0]     mag;

  always_comb begin
    sum_l = 10'(req_i.tl) + {1'b0, req_i.ml, 1'b0} + 10'(req_i.bl);
    sum_r = 10'(req_i.tr) + {1'b0, req_i.mr, 1'b0} + 10'(req_i.br);
    sum_t = 10'(req_i.tl) + {1'b0, req_i.tc, 1'b0} + 10'(req_i.tr);
    sum_b = 10'(req_i.bl) + {1'b0, req_i.bc, 1'b0} + 10'(req_i.br);
    gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    gy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
  end

  assign o_ready     = !o_v_q || out_ready_i;
  assign g_ready     = !g_v_q || o_ready;
  assign req_ready_o = g_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (g_ready) begin
        g_v_q <= req_valid_i;
      end
      if (o_ready) begin
        o_v_q <= g_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_ready && req_valid_i) begin
      ax_q     <= sat_abs(gx);
      ay_q     <= sat_abs(gy);
      g_row_q  <= req_i.row;
      g_col_q  <= req_i.col;
      g_last_q <= req_i.last;
    end
    if (o_ready && g_v_q) begin
      o_mag_q  <= mag;
      o_edge_q <= (mag > thresh_i) ? EDGE_ON : EDGE_OFF;
      o_row_q  <= g_row_q;
      o_col_q  <= g_col_q;
      o_last_q <= g_last_q;
    end
  end

  assign mag = round_mean(ax_q, ay_q);

  assign out_valid_o = o_v_q;
  assign out_last_o  = o_last_q;
  assign out_data_o  = {(OUT_DATA_W - OUT_USED_W)'(0), o_edge_q, o_mag_q, o_col_q, o_row_q};

endmodule

// ===== sv/sobel_edge_threshold.sv =====
// Streaming 3x3 Sobel edge detector with threshold; top level.
// Depends on sobel_pkg and sobel_grad.
//
// Pixels enter in raster order at one per clock when not stalled. Results for a
// row come out while the next row streams in, each word tagged with its row and
// column; the first row's results appear as the second row arrives. Below the
// first row, an input pixel at the last column of a row releases two results,
// and each pixel of the last row releases twice as many as on other rows. A
// pixel holds the input until the single result path after the window has taken
// all of its results, at most four. Both previous rows live in one line memory
// of MAX_WIDTH words, read when a pixel is taken and written back as it moves
// into the window, so a row at least two pixels wide never needs forwarding.
// From input to output the pipeline is four registers deep.
// Configuration is taken at any time but must only change between frames.
module sobel_edge_threshold #(
  parameter int unsigned MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // s_axis_tdata: pixel_value
  input  logic [sobel_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // m_axis_tdata: out_row, out_col, gradient_magnitude, edge_pixel, zero pad
  output logic [sobel_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // m_axis_tlast: last_of_run
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sobel_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam logic [CW-1:0] WLAST_RST = CW'(dim_last(FRAME_WIDTH_RST, 13'(MAX_WIDTH)));
  localparam logic [RW-1:0] HLAST_RST = RW'(dim_last(FRAME_HEIGHT_RST, 13'(MAX_HEIGHT)));

  // Result slots a pixel can release, in output order.
  localparam int unsigned E_ABOVE_PREV = 0;
  localparam int unsigned E_ABOVE_LAST = 1;
  localparam int unsigned E_CUR_PREV   = 2;
  localparam int unsigned E_CUR_LAST   = 3;

  logic [CW-1:0]    wlast_q;
  logic [RW-1:0]    hlast_q;
  logic [MAG_W-1:0] thresh_q;

  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic             acc;
  logic             at_lastcol, at_lastrow, row_nz, col_nz;
  logic [3:0]       mask_in;

  // Line memory: entry c holds {row r-2, row r-1} at column c.
  logic [2*PIX_W-1:0] lbuf_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic             s1_v_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_col_q;
  logic [RW-1:0]    s1_row_q;
  logic [3:0]       s1_mask_q;
  logic             s1_r1_q, s1_c1_q, s1_over_q;
  logic             s1_adv;

  sobel_col_t       win_q [3];
  logic [3:0]       s2_mask_q;
  logic [CW-1:0]    s2_col_q;
  logic [RW-1:0]    s2_row_q;
  logic             s2_r1_q, s2_c1_q, s2_over_q;
  logic             s2_free;

  logic [3:0]       sel;
  logic             last_emit;
  logic             cur_phase;
  sobel_col_t       col_l, col_c, col_r;
  logic [CW-1:0]    x;
  logic [RW-1:0]    y;
  sobel_req_t       req;
  logic             req_valid, req_ready, fire;

  // Configuration.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q  <= WLAST_RST;
      hlast_q  <= HLAST_RST;
      thresh_q <= EDGE_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:    wlast_q  <= CW'(dim_last(cfg_data_i, 13'(MAX_WIDTH)));
        CFG_FRAME_HEIGHT:   hlast_q  <= RW'(dim_last(cfg_data_i, 13'(MAX_HEIGHT)));
        CFG_EDGE_THRESHOLD: thresh_q <= cfg_data_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Input stage and raster counters.
  assign acc        = s_axis_tvalid && s_axis_tready;
  assign at_lastcol = col_q >= wlast_q;
  assign at_lastrow = row_q >= hlast_q;
  assign row_nz     = row_q != '0;
  assign col_nz     = col_q != '0;

  always_comb begin
    mask_in               = '0;
    mask_in[E_ABOVE_PREV] = row_nz && col_nz;
    mask_in[E_ABOVE_LAST] = row_nz && at_lastcol;
    mask_in[E_CUR_PREV]   = row_nz && at_lastrow && col_nz;
    mask_in[E_CUR_LAST]   = row_nz && at_lastrow && at_lastcol;
  end

  assign s2_free       = !req_valid || (fire && last_emit);
  assign s1_adv        = s1_v_q && s2_free;
  assign s_axis_tready = !s1_v_q || s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      s1_v_q    <= 1'b0;
      s2_mask_q <= '0;
    end else begin
      if (acc) begin
        if (at_lastcol) begin
          col_q <= '0;
          row_q <= at_lastrow ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_mask_q <= s1_mask_q;
      end else if (fire) begin
        s2_mask_q <= s2_mask_q & ~sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q      <= lbuf_mem[col_q];
      s1_pix_q  <= s_axis_tdata[PIX_W-1:0];
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_mask_q <= mask_in;
      s1_r1_q   <= row_q == RW'(1);
      s1_c1_q   <= col_q == CW'(1);
      s1_over_q <= col_q > wlast_q;
    end
  end

  // Write back the shifted rows once, as the pixel moves into the window.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      lbuf_mem[s1_col_q] <= {rd_q[PIX_W-1:0], s1_pix_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q[2]  <= win_q[1];
      win_q[1]  <= win_q[0];
      win_q[0]  <= '{o: rd_q[2*PIX_W-1:PIX_W], n: rd_q[PIX_W-1:0], p: s1_pix_q};
      s2_col_q  <= s1_col_q;
      s2_row_q  <= s1_row_q;
      s2_r1_q   <= s1_r1_q;
      s2_c1_q   <= s1_c1_q;
      s2_over_q <= s1_over_q;
    end
  end

  // Result sequencer: one pending result per cycle while sobel_grad is ready, lowest slot first.
  always_comb begin
    sel       = s2_mask_q & (~s2_mask_q + 4'd1);
    last_emit = (s2_mask_q & ~sel) == 4'd0;
    cur_phase = sel[E_CUR_PREV] || sel[E_CUR_LAST];

    if (sel[E_ABOVE_LAST] || sel[E_CUR_LAST]) begin
      // At the last column the right neighbor mirrors to the left one.
      col_l = win_q[1];
      col_c = win_q[0];
      col_r = win_q[1];
      x     = s2_col_q;
    end else begin
      // Column zero mirrors its left neighbor from column one.
      col_l = s2_c1_q ? win_q[0] : win_q[2];
      col_c = win_q[1];
      col_r = s2_over_q ? win_q[2] : win_q[0];
      x     = s2_col_q - CW'(1);
    end
    y = cur_phase ? s2_row_q : s2_row_q - RW'(1);

    if (cur_phase) begin
      // Last row: the row below mirrors to the row above.
      req.tl = col_l.n;
      req.tc = col_c.n;
      req.tr = col_r.n;
      req.ml = col_l.p;
      req.mr = col_r.p;
      req.bl = col_l.n;
      req.bc = col_c.n;
      req.br = col_r.n;
    end else begin
      // For row zero the row above mirrors to row one.
      req.tl = s2_r1_q ? col_l.p : col_l.o;
      req.tc = s2_r1_q ? col_c.p : col_c.o;
      req.tr = s2_r1_q ? col_r.p : col_r.o;
      req.ml = col_l.n;
      req.mr = col_r.n;
      req.bl = col_l.p;
      req.bc = col_c.p;
      req.br = col_r.p;
    end
    req.row  = OUT_ROW_W'(y);
    req.col  = OUT_COL_W'(x);
    req.last = last_emit;
  end

  assign req_valid = s2_mask_q != 4'd0;
  assign fire      = req_valid && req_ready;

  sobel_grad u_grad (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .thresh_i    (thresh_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s1_adv |=> s1_v_q && $stable(s1_col_q))
    else $error("pixel waiting for the window lost its place");

  a_mask_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_mask_q != 4'd0) && !s1_adv |=> ((s2_mask_q & ~$past(s2_mask_q)) == 4'd0))
    else $error("pending result slots grew without a new pixel");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_emit |=> (s2_mask_q == 4'd0) || $past(s1_adv))
    else $error("results still pending after the word marked last");

endmodule
